// File: rtl/core/bitmap_slot_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Bitmap slot allocator assertion macros
// Shared assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Shared constants, request codes and controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  localparam int WORD_COUNT_DEF = 16;
  localparam int WORD_BITS_DEF  = 64;

  localparam int SLOT_W  = 10;
  localparam int TDATA_W = 16;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_MOD
  } bsa_state_e;

endpackage

`default_nettype wire

// File: rtl/core/bitmap_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// First-free slot allocator over an occupancy bitmap held in a word memory.
// ----------------------------------------------------------------------------
// Usage: one request word enters on the s_axis channel and exactly one result
// word leaves on the m_axis channel. tuser carries the request kind: allocate
// or free. An allocate returns the lowest free slot with success set, or
// index 0 with success clear when every slot is taken. A free with a valid
// handle clears that slot and reports success only if the slot was in use.
// An allocate runs from acceptance to the result register thus: a
// per-word full-flag register picks the first non-full word in the accept
// cycle, then one read-modify-write of that memory word follows. A free
// first passes a split step that splits the slot index into word and bit.
// One request is in flight at a time: a new request is accepted only once
// the last one's result has been loaded into the result register.
// Reset empties the bitmap at once; no clearing pass is needed.
// When the receiver stalls, the next request is still accepted and worked
// on, and it waits at its final step until the result register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator_unit #(
  parameter int WORD_COUNT = bsa_pkg::WORD_COUNT_DEF,
  parameter int WORD_BITS  = bsa_pkg::WORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output      logic                         s_axis_tready_o,
  // [9:0] slot_index, [10] handle_valid, [15:11] zero
  input  wire logic [bsa_pkg::TDATA_W-1:0]  s_axis_tdata_i,
  // [0] mode
  input  wire logic                         s_axis_tuser_i,
  output      logic                         m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [9:0] granted_index, [10] success, [15:11] zero
  output      logic [bsa_pkg::TDATA_W-1:0]  m_axis_tdata_o
);

  import bsa_pkg::*;

  localparam int AW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int SlotCount = WORD_COUNT * WORD_BITS;
  localparam int RecipMul  = 65536 / WORD_BITS;
  localparam int ProdW     = SLOT_W + 17;

  bsa_state_e            state_q, state_d;
  logic                  mode_q, mode_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic                  hvld_q, hvld_d;
  logic [SLOT_W-1:0]     west_q, west_d;
  logic [AW-1:0]         word_q, word_d;
  logic [BW-1:0]         bit_q, bit_d;
  logic                  ok_q, ok_d;
  logic                  all_full_q, all_full_d;
  logic [WORD_COUNT-1:0] full_q, full_d;
  logic                  out_vld_q, out_vld_d;
  logic [TDATA_W-1:0]    out_data_q, out_data_d;

  logic                  accept;
  logic                  out_load;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;
  logic                  ram_we;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [AW-1:0]         first_free_word;
  logic [BW-1:0]         first_free_bit;
  logic [ProdW-1:0]      div_prod;
  logic [16:0]           base;
  logic [16:0]           rem;
  logic                  rem_ge;
  logic [SLOT_W-1:0]     word_fix;
  logic                  in_range;
  logic [SLOT_W-1:0]     grant_idx;

  always_comb begin
    first_free_word = '0;
    for (int i = WORD_COUNT - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        first_free_word = AW'(i);
      end
    end
  end

  always_comb begin
    first_free_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!ram_rdata[i]) begin
        first_free_bit = BW'(i);
      end
    end
  end

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == ST_MOD) && (!out_vld_q || m_axis_tready_i);

  assign div_prod = ProdW'(s_axis_tdata_i[SLOT_W-1:0]) * ProdW'(RecipMul);
  assign base     = 17'(west_q) * 17'(WORD_BITS);
  assign rem      = 17'(slot_q) - base;
  assign rem_ge   = rem >= 17'(WORD_BITS);
  assign word_fix = rem_ge ? (west_q + SLOT_W'(1)) : west_q;
  assign in_range = 32'(slot_q) < 32'(SlotCount);

  assign grant_idx = SLOT_W'(32'(word_q) * 32'(WORD_BITS) + 32'(first_free_bit));

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    slot_d     = slot_q;
    hvld_d     = hvld_q;
    west_d     = west_q;
    word_d     = word_q;
    bit_d      = bit_q;
    ok_d       = ok_q;
    all_full_d = all_full_q;
    full_d     = full_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    ram_re     = 1'b0;
    ram_raddr  = word_q;
    ram_we     = 1'b0;
    ram_wdata  = ram_rdata;
    s_axis_tready_o = (state_q == ST_IDLE);

    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d     = s_axis_tuser_i;
          slot_d     = s_axis_tdata_i[SLOT_W-1:0];
          hvld_d     = s_axis_tdata_i[SLOT_W];
          west_d     = div_prod[SLOT_W+15:16];
          word_d     = first_free_word;
          all_full_d = &full_q;
          if (s_axis_tuser_i == MODE_ALLOC) begin
            ram_re    = 1'b1;
            ram_raddr = first_free_word;
            state_d   = ST_MOD;
          end else begin
            state_d = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        word_d    = word_fix[AW-1:0];
        bit_d     = rem_ge ? BW'(rem - 17'(WORD_BITS)) : BW'(rem);
        ok_d      = hvld_q && in_range;
        ram_re    = 1'b1;
        ram_raddr = word_fix[AW-1:0];
        state_d   = ST_MOD;
      end
      ST_MOD: begin
        if (out_load) begin
          out_vld_d  = 1'b1;
          out_data_d = '0;
          state_d    = ST_IDLE;
          if (mode_q == MODE_ALLOC) begin
            if (!all_full_q) begin
              ram_we = 1'b1;
              ram_wdata = ram_rdata | (WORD_BITS'(1) << first_free_bit);
              full_d[word_q] = &ram_wdata;
              out_data_d[SLOT_W-1:0] = grant_idx;
              out_data_d[SLOT_W] = 1'b1;
            end
          end else begin
            if (ok_q && ram_rdata[bit_q]) begin
              ram_we = 1'b1;
              ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_q);
              full_d[word_q] = 1'b0;
              out_data_d[SLOT_W] = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      full_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      full_q    <= full_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    slot_q     <= slot_d;
    hvld_q     <= hvld_d;
    west_q     <= west_d;
    word_q     <= word_d;
    bit_q      <= bit_d;
    ok_q       <= ok_d;
    all_full_q <= all_full_d;
    out_data_q <= out_data_d;
  end

  bsa_bitmap_ram #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BITS  (WORD_BITS),
    .AW         (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (ram_wdata)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

`include "bitmap_slot_allocator_unit_macros.svh"

  `BSA_ASSERT_SAME(a_write_only_at_result, clk_i, rst_ni, ram_we, out_load && (state_q == ST_MOD), "Memory write outside the result step.")
  `BSA_ASSERT_NEXT(a_alloc_reads_next, clk_i, rst_ni, accept && (s_axis_tuser_i == MODE_ALLOC), (state_q == ST_MOD) && !s_axis_tready_o, "Allocate did not move to the modify step.")
  `BSA_ASSERT_SAME(a_fail_index_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tdata_o[SLOT_W], m_axis_tdata_o[SLOT_W-1:0] == '0, "Failed result carries a nonzero index.")

endmodule

`default_nettype wire

// File: rtl/core/bsa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// Bitmap word memory
// Single-port-write, single-read synchronous memory with per-word written
// flags, so that a word never written since reset reads as all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_bitmap_ram #(
  parameter int WORD_COUNT = 16,
  parameter int WORD_BITS  = 64,
  parameter int AW         = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr_i,
  output      logic [WORD_BITS-1:0]  rdata_o,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [WORD_BITS-1:0]  wdata_i
);

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] written_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= written_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire
